### hw/rtl/deq_pkg.sv
package deq_pkg;

  // Operation codes carried in the operation field
  typedef enum logic [2:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_PEEK       = 3'd4
  } op_e;

  // Status codes reported with every result beat
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  // Input beat
  typedef struct packed {
    logic [2:0]         operation;
    logic signed [31:0] value;
  } in_t;

  // Result beat
  typedef struct packed {
    logic signed [31:0] popped_value;
    logic signed [31:0] front_value;
    logic signed [31:0] back_value;
    logic               is_empty;
    logic               is_full;
    logic [4:0]         entry_count;
    logic [1:0]         status;
  } out_t;

  // Per-chain command broadcast to every cell
  typedef struct packed {
    logic shift_up;    // take the neighbor nearer the head, head cell takes the new value
    logic shift_down;  // take the neighbor farther from the head
    logic tail_load;   // cell at the tail position takes the new value
  } cell_ctrl_t;

endpackage

### hw/rtl/double_ended_queue_core.sv
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   deq_pkg::in_t  (operation, value)
// out      output     out_valid_o / out_ready_i deq_pkg::out_t (values, flags, count, status)
//
// Items are taken one at a time: the item updates the cell chains at its
// accept edge and its result beat shows on the next cycle; a new item is taken
// once that beat has been accepted.
// Two mirrored chains of DEPTH cells hold the entries, one with the front at its
// head, one with the back at its head, so both ends are read at a fixed cell.
// Reset clears the entry count and the output valid; cell contents need none.
// A stalled result beat holds, and holds off the input side.
module double_ended_queue_core #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  deq_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output deq_pkg::out_t  out_data_o
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic                  accept;
  logic                  empty, full;
  logic [DATA_WIDTH-1:0] in_value;
  logic [DATA_WIDTH-1:0] front_head, back_head;
  deq_pkg::cell_ctrl_t   front_ctrl, back_ctrl;
  logic [CNT_W-1:0]      count_d, count_q;
  logic                  out_valid_d, out_valid_q;
  logic [DATA_WIDTH-1:0] popped_d, popped_q;
  deq_pkg::status_e      status_d, status_q;

  assign in_ready_o = !out_valid_q;
  assign accept     = in_valid_i && in_ready_o;
  assign empty      = (count_q == '0);
  assign full       = (count_q == CNT_W'(DEPTH));
  assign in_value   = DATA_WIDTH'($unsigned(in_data_i.value));

  // Decode the operation into chain commands, the new count and status
  always_comb begin
    front_ctrl = '0;
    back_ctrl  = '0;
    count_d    = count_q;
    popped_d   = popped_q;
    status_d   = status_q;
    if (accept) begin
      popped_d = '0;
      status_d = deq_pkg::STATUS_OK;
      case (deq_pkg::op_e'(in_data_i.operation))
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            front_ctrl.shift_up = 1'b1;
            back_ctrl.tail_load = 1'b1;
            count_d             = count_q + CNT_W'(1);
          end
        end
        deq_pkg::OP_PUSH_BACK: begin
          if (full) begin
            status_d = deq_pkg::STATUS_OVERFLOW;
          end else begin
            back_ctrl.shift_up   = 1'b1;
            front_ctrl.tail_load = 1'b1;
            count_d              = count_q + CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            status_d = deq_pkg::STATUS_UNDERFLOW;
          end else begin
            popped_d              = front_head;
            front_ctrl.shift_down = 1'b1;
            count_d               = count_q - CNT_W'(1);
          end
        end
        deq_pkg::OP_POP_BACK: begin
          if (empty) begin
            status_d = deq_pkg::STATUS_UNDERFLOW;
          end else begin
            popped_d             = back_head;
            back_ctrl.shift_down = 1'b1;
            count_d              = count_q - CNT_W'(1);
          end
        end
        default: begin
          // peek and unused codes: leave the contents alone
        end
      endcase
    end
  end

  // Raise the result beat after an accept, drop it once taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    popped_q <= popped_d;
    status_q <= status_d;
  end

  // Front chain: head is the front entry, tail slot is the back end
  deq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_front_chain (
    .clk_i   (clk_i),
    .ctrl_i  (front_ctrl),
    .tail_i  (count_q),
    .value_i (in_value),
    .head_o  (front_head)
  );

  // Back chain: mirror image, head is the back entry
  deq_chain #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_back_chain (
    .clk_i   (clk_i),
    .ctrl_i  (back_ctrl),
    .tail_i  (count_q),
    .value_i (in_value),
    .head_o  (back_head)
  );

  // Assemble the result beat from the settled chains
  assign out_valid_o             = out_valid_q;
  assign out_data_o.popped_value = 32'(popped_q);
  assign out_data_o.front_value  = empty ? '0 : 32'(front_head);
  assign out_data_o.back_value   = empty ? '0 : 32'(back_head);
  assign out_data_o.is_empty     = empty;
  assign out_data_o.is_full      = full;
  assign out_data_o.entry_count  = 5'(count_q);
  assign out_data_o.status       = status_q;

endmodule

### hw/rtl/deq_cell.sv
module deq_cell #(
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5,
  parameter int IDX        = 0
) (
  input  logic                  clk_i,
  input  deq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]      tail_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] data_o
);

  logic [DATA_WIDTH-1:0] data_d, data_q;

  // Select the next entry: shift either way, or load at the tail slot
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      data_d = prev_i;
    end else if (ctrl_i.shift_down) begin
      data_d = next_i;
    end else if (ctrl_i.tail_load && (tail_i == CNT_W'(IDX))) begin
      data_d = value_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

### hw/rtl/deq_chain.sv
module deq_chain #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32,
  parameter int CNT_W      = 5
) (
  input  logic                  clk_i,
  input  deq_pkg::cell_ctrl_t   ctrl_i,
  input  logic [CNT_W-1:0]      tail_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  output logic [DATA_WIDTH-1:0] head_o
);

  logic [DATA_WIDTH-1:0] data [DEPTH];

  // Link each cell to its neighbors; the head cell shifts in the new value
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_data, next_data;

    if (i == 0) begin : g_head
      assign prev_data = value_i;
    end else begin : g_body
      assign prev_data = data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_data = data[i];
    end else begin : g_inner
      assign next_data = data[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .CNT_W      (CNT_W),
      .IDX        (i)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl_i),
      .tail_i  (tail_i),
      .value_i (value_i),
      .prev_i  (prev_data),
      .next_i  (next_data),
      .data_o  (data[i])
    );
  end

  assign head_o = data[0];

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int DEPTH       = 16;
  localparam int DATA_WIDTH  = 32;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_GAP     = 30;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  deq_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  deq_pkg::out_t out_data_o;

  double_ended_queue_core #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  // Shadow copy of the deque
  logic [DATA_WIDTH-1:0] ring_slots [DEPTH];
  logic [IDX_W-1:0]      ring_front = '0;
  logic [IDX_W-1:0]      ring_back  = '0;
  logic [4:0]            ring_count = '0;

  deq_pkg::out_t pending_snapshots [$];
  int   error_count    = 0;
  int   cycle_count    = 0;
  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Apply one operation to the shadow deque and return the result beat it should produce
  function automatic deq_pkg::out_t predict_deque(deq_pkg::in_t item);
    deq_pkg::out_t res;
    res = '0;
    res.status = deq_pkg::STATUS_OK;
    case (item.operation)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_BACK: begin
        if (ring_count == DEPTH) begin
          res.status = deq_pkg::STATUS_OVERFLOW;
        end else if (item.operation == deq_pkg::OP_PUSH_FRONT) begin
          ring_front = ring_front - 1'b1;
          ring_slots[ring_front] = item.value;
          ring_count = ring_count + 1'b1;
        end else begin
          ring_slots[ring_back] = item.value;
          ring_back  = ring_back + 1'b1;
          ring_count = ring_count + 1'b1;
        end
      end
      deq_pkg::OP_POP_FRONT, deq_pkg::OP_POP_BACK: begin
        if (ring_count == 0) begin
          res.status = deq_pkg::STATUS_UNDERFLOW;
        end else if (item.operation == deq_pkg::OP_POP_FRONT) begin
          res.popped_value = ring_slots[ring_front];
          ring_front = ring_front + 1'b1;
          ring_count = ring_count - 1'b1;
        end else begin
          ring_back = ring_back - 1'b1;
          res.popped_value = ring_slots[ring_back];
          ring_count = ring_count - 1'b1;
        end
      end
      // peek and the unused codes leave the deque alone
      default: ;
    endcase
    if (ring_count != 0) begin
      res.front_value = ring_slots[ring_front];
      res.back_value  = ring_slots[IDX_W'(ring_back - 1'b1)];
    end
    res.is_empty    = (ring_count == 0);
    res.is_full     = (ring_count == DEPTH);
    res.entry_count = ring_count;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0d: %s", cycle_count, msg);
    error_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h expected %h", field, got, want));
    end
  endtask

  // Stall the result channel at the current rate
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk_i) begin
    deq_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_snapshots.size() == 0) begin
        report_mismatch("result beat with no pending prediction");
      end else begin
        want = pending_snapshots.pop_front();
        check_field("popped_value", out_data_o.popped_value, want.popped_value);
        check_field("front_value", out_data_o.front_value, want.front_value);
        check_field("back_value", out_data_o.back_value, want.back_value);
        check_field("is_empty", 32'(out_data_o.is_empty), 32'(want.is_empty));
        check_field("is_full", 32'(out_data_o.is_full), 32'(want.is_full));
        check_field("entry_count", 32'(out_data_o.entry_count), 32'(want.entry_count));
        check_field("status", 32'(out_data_o.status), 32'(want.status));
      end
    end
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("double_ended_queue_core: mismatch");
      $finish;
    end
  end

  // Drive one input beat, leaving valid high on return
  task automatic send_item(input logic [2:0] op, input logic [31:0] val);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{operation: op, value: val};
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    pending_snapshots.push_back(predict_deque(in_data_i));
  endtask

  // Drop valid and hold until every predicted beat has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_snapshots.size() != 0);
  endtask

  // Pops on an empty deque, peek and the unused operation codes
  task automatic test_empty_faults();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(deq_pkg::OP_POP_FRONT, 32'h1234_5678);
    send_item(deq_pkg::OP_POP_BACK, 32'hffff_ffff);
    send_item(deq_pkg::OP_PEEK, 32'h0);
    for (int code = 5; code <= 7; code++) send_item(3'(code), $urandom());
  endtask

  // Fill from both ends with extreme values, then push into a full deque
  task automatic test_full_overflow();
    logic [31:0] edge_vals [4];
    edge_vals = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
    for (int i = 0; i < DEPTH / 2; i++) begin
      send_item(deq_pkg::OP_PUSH_FRONT, (i < 4) ? edge_vals[i] : $urandom());
    end
    for (int i = 0; i < DEPTH / 2; i++) begin
      send_item(deq_pkg::OP_PUSH_BACK, (i < 4) ? edge_vals[3 - i] : $urandom());
    end
    send_item(deq_pkg::OP_PUSH_FRONT, 32'h5555_5555);
    send_item(deq_pkg::OP_PUSH_BACK, 32'haaaa_aaaa);
    send_item(deq_pkg::OP_PEEK, 32'h0);
  endtask

  // Random traffic that swings between filling and emptying the deque
  task automatic test_random_traffic(input int count, input int idle_pct,
                                     input int stall_pct);
    int          push_pct;
    int          roll;
    logic [2:0]  op;
    logic [31:0] val;
    wait_for_drain();
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    push_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) push_pct = $urandom_range(0, 1) ? 75 : 25;
      roll = $urandom_range(0, 99);
      if (roll < 6) begin
        op = 3'($urandom_range(deq_pkg::OP_PEEK, 7));
      end else if (roll < 6 + push_pct * 94 / 100) begin
        op = $urandom_range(0, 1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      end else begin
        op = $urandom_range(0, 1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_BACK;
      end
      case ($urandom_range(0, 15))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7fff_ffff;
        2:       val = 32'h0000_0000;
        3:       val = 32'hffff_ffff;
        default: val = $urandom();
      endcase
      send_item(op, val);
    end
  endtask

  // Hold the sender off mid-stream until the deque has answered everything
  task automatic test_paused_sender();
    send_idle_pct  = 0;
    recv_stall_pct = 67;
    for (int i = 0; i < 20; i++) begin
      send_item(3'($urandom_range(deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PEEK)), $urandom());
    end
    wait_for_drain();
    for (int i = 0; i < 20; i++) begin
      send_item(3'($urandom_range(deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PEEK)), $urandom());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_faults();
    test_full_overflow();
    test_random_traffic(500, 0, 0);
    test_random_traffic(500, 67, 0);
    test_paused_sender();
    test_random_traffic(500, 0, 67);
    test_random_traffic(500, 20, 20);
    wait_for_drain();
    repeat (20) @(posedge clk_i);
    if (pending_snapshots.size() != 0) begin
      report_mismatch("predictions left without a result beat");
    end
    if (error_count == 0) begin
      $display("double_ended_queue_core: match");
    end else begin
      $display("double_ended_queue_core: mismatch");
    end
    $finish;
  end

endmodule
